[design/blfb_pkg.sv]
// Shared types, constants and the shade character table for the glyph readout framebuffer.
package blfb_pkg;

	// Default grid and cell geometry
	localparam int MAX_WIDTH_DEF  = 256;
	localparam int MAX_HEIGHT_DEF = 128;
	localparam int VALUE_BITS_DEF = 16;

	// Fixed field widths
	localparam int COORD_W  = 16;
	localparam int VAL_IN_W = 16;
	localparam int CFG_W    = 9;
	localparam int WIDTH_W  = 9;
	localparam int HEIGHT_W = 8;

	// Fixed point: 12 fraction bits, 4096 is 1.0
	localparam int FRAC_BITS = 12;
	localparam int FRAC_ONE  = 4096;
	localparam int LEVELS    = 8;
	localparam int LEVEL_W   = 3;
	localparam int CHAR_W    = 8;
	localparam int N_W       = 13;
	localparam int WIDE_W    = 48;

	localparam logic [WIDTH_W-1:0]  ACTIVE_WIDTH_RST  = 9'd256;
	localparam logic [HEIGHT_W-1:0] ACTIVE_HEIGHT_RST = 8'd128;

	// Register indexes on the configuration port
	localparam logic CFG_ACTIVE_WIDTH  = 1'b0;
	localparam logic CFG_ACTIVE_HEIGHT = 1'b1;

	typedef enum logic [2:0] {
		ACT_OVERWRITE = 3'd0,
		ACT_ALPHA     = 3'd1,
		ACT_ADD       = 3'd2,
		ACT_READ      = 3'd3,
		ACT_FILL      = 3'd4
	} action_t;

	typedef enum logic {
		ST_CLEAR,
		ST_RUN
	} fsm_t;

	// Control of the one item in flight
	typedef struct packed {
		logic    valid;
		action_t action;
		logic    inr;
	} item_ctl_t;

	function automatic logic [CHAR_W-1:0] shade_char(input logic [LEVEL_W-1:0] lvl);
		logic [CHAR_W-1:0] c;
		case (lvl)
			3'd0: c = 8'h20; // ' '
			3'd1: c = 8'h2D; // '-'
			3'd2: c = 8'h7E; // '~'
			3'd3: c = 8'h2B; // '+'
			3'd4: c = 8'h3D; // '='
			3'd5: c = 8'h6F; // 'o'
			3'd6: c = 8'h26; // '&'
			3'd7: c = 8'h40; // '@'
			default: c = 8'h20;
		endcase
		return c;
	endfunction

endpackage

[design/blend_framebuffer_glyph_readout.sv]
// Top level of the intensity framebuffer with blended writes and shade glyph readout.
//
// A grid of MAX_WIDTH x MAX_HEIGHT signed Q4.12 cells (4096 = 1.0, VALUE_BITS wide) lives in
// one synchronous RAM at address x*MAX_HEIGHT+y. Actions: 0 overwrite, 1 alpha over
// 1-(1-old)(1-new), 2 saturating add (all with the new value clamped to 0..1), 4 raw fill
// (unclamped, negative marks the cell transparent), 3 read, which returns one result beat with
// the shade level round(v*7) clamped to 0..7, its character from " -~+=o&@", the transparent
// flag, the raw value and an in-range flag. Writes outside the active grid and actions 5..7
// are dropped without a result. After reset the block sweeps the RAM to zero, one cell a
// clock, so in_stall stays high until every cell has been cleared; configuration writes
// are taken during the sweep. Each beat then passes through RAM read, blend multiply, and
// round/saturate and write back, with a single item in flight so the read-modify-write never
// overlaps another access to the same cell. The result register lets a new beat in while a
// read result still waits on out_stall; a second read result waits in the write-back stage
// until the first one has gone.
module blend_framebuffer_glyph_readout
	import blfb_pkg::*;
#(
	parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = MAX_HEIGHT_DEF,
	parameter int VALUE_BITS = VALUE_BITS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	// configuration
	input  logic                       cfg_we,
	input  logic                       cfg_index,
	input  logic [CFG_W-1:0]           cfg_data,
	// item channel
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic [2:0]                 action,
	input  logic signed [COORD_W-1:0]  x_coord,
	input  logic signed [COORD_W-1:0]  y_coord,
	input  logic signed [VAL_IN_W-1:0] value,
	// result channel
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic [LEVEL_W-1:0]         glyph_index,
	output logic [CHAR_W-1:0]          glyph_char,
	output logic                       transparent,
	output logic signed [VAL_IN_W-1:0] cell_value,
	output logic                       in_range
);

	localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int X_W    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam int Y_W    = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
	localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);

	// Configuration registers
	logic [WIDTH_W-1:0]  active_width_q;
	logic [HEIGHT_W-1:0] active_height_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_width_q  <= ACTIVE_WIDTH_RST;
			active_height_q <= ACTIVE_HEIGHT_RST;
		end else if (cfg_we) begin
			if (cfg_index == CFG_ACTIVE_WIDTH) begin
				active_width_q <= cfg_data[WIDTH_W-1:0];
			end
			if (cfg_index == CFG_ACTIVE_HEIGHT) begin
				active_height_q <= cfg_data[HEIGHT_W-1:0];
			end
		end
	end

	// Clear sweep sequencer
	fsm_t              state_q;
	fsm_t              state_d;
	logic [ADDR_W-1:0] clr_cnt_q;
	logic              clearing;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: begin
				if (clr_cnt_q == LAST_ADDR) state_d = ST_RUN;
			end
			ST_RUN:   state_d = ST_RUN;
			default:  state_d = ST_CLEAR;
		endcase
	end

	always_comb begin
		case (state_q)
			ST_CLEAR: clearing = 1'b1;
			ST_RUN:   clearing = 1'b0;
			default:  clearing = 1'b1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_CLEAR;
			clr_cnt_q <= '0;
		end else begin
			state_q <= state_d;
			if (clearing) clr_cnt_q <= clr_cnt_q + ADDR_W'(1);
		end
	end

	// Accept and range check
	item_ctl_t         ctl_s1;
	item_ctl_t         ctl_s2;
	logic              accept;
	logic              x_ok;
	logic              y_ok;
	logic              inr;
	logic              keep;
	logic [ADDR_W-1:0] addr;
	logic [ADDR_W-1:0] addr_s1;
	logic [ADDR_W-1:0] addr_s2;
	logic signed [VAL_IN_W-1:0] value_s1;

	// one item in flight: the write back must land before the next read
	assign in_stall = clearing || ctl_s1.valid || ctl_s2.valid;
	assign accept   = in_valid && !in_stall;

	always_comb begin
		x_ok = !x_coord[COORD_W-1]
			&& ({1'b0, x_coord[COORD_W-2:0]} < COORD_W'(active_width_q))
			&& (int'(x_coord[COORD_W-2:0]) < MAX_WIDTH);
		y_ok = !y_coord[COORD_W-1]
			&& ({1'b0, y_coord[COORD_W-2:0]} < COORD_W'(active_height_q))
			&& (int'(y_coord[COORD_W-2:0]) < MAX_HEIGHT);
		inr  = x_ok && y_ok;
		addr = ADDR_W'(x_coord[X_W-1:0]) * ADDR_W'(MAX_HEIGHT) + ADDR_W'(y_coord[Y_W-1:0]);
		// reads always answer; writes only inside the grid; unknown actions vanish
		case (action_t'(action))
			ACT_READ:                           keep = 1'b1;
			ACT_OVERWRITE, ACT_ALPHA, ACT_ADD,
			ACT_FILL:                           keep = inr;
			default:                            keep = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else begin
			ctl_s1.valid  <= accept && keep;
			ctl_s1.action <= action_t'(action);
			ctl_s1.inr    <= inr;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			addr_s1  <= addr;
			value_s1 <= value;
		end
		if (ctl_s1.valid) begin
			addr_s2 <= addr_s1;
		end
	end

	// Cell RAM
	logic                         wb_en;
	logic                         mem_we;
	logic [ADDR_W-1:0]            mem_waddr;
	logic signed [VALUE_BITS-1:0] wb_data;
	logic signed [VALUE_BITS-1:0] mem_wdata;
	logic signed [VALUE_BITS-1:0] old_s1;

	assign mem_we    = clearing || wb_en;
	assign mem_waddr = clearing ? clr_cnt_q : addr_s2;
	assign mem_wdata = clearing ? '0 : wb_data;

	blfb_cell_mem #(
		.DEPTH      (DEPTH),
		.VALUE_BITS (VALUE_BITS)
	) u_mem (
		.clk     (clk),
		.wr_en   (mem_we),
		.wr_addr (mem_waddr),
		.wr_data (mem_wdata),
		.rd_en   (accept),
		.rd_addr (addr),
		.rd_data (old_s1)
	);

	// Blend and quantise
	logic                       res_ready;
	logic                       res_valid;
	logic [LEVEL_W-1:0]         res_glyph_index;
	logic [CHAR_W-1:0]          res_glyph_char;
	logic                       res_transparent;
	logic signed [VAL_IN_W-1:0] res_cell_value;
	logic                       res_in_range;
	logic                       out_valid_q;

	assign res_ready = !out_valid_q || !out_stall;

	blfb_blend #(
		.VALUE_BITS (VALUE_BITS)
	) u_blend (
		.clk             (clk),
		.arst_n          (arst_n),
		.ctl_s1          (ctl_s1),
		.value_s1        (value_s1),
		.old_s1          (old_s1),
		.res_ready       (res_ready),
		.ctl_s2          (ctl_s2),
		.wr_en           (wb_en),
		.wr_data         (wb_data),
		.res_valid       (res_valid),
		.res_glyph_index (res_glyph_index),
		.res_glyph_char  (res_glyph_char),
		.res_transparent (res_transparent),
		.res_cell_value  (res_cell_value),
		.res_in_range    (res_in_range)
	);

	// Result register
	logic [LEVEL_W-1:0]         glyph_index_q;
	logic [CHAR_W-1:0]          glyph_char_q;
	logic                       transparent_q;
	logic signed [VAL_IN_W-1:0] cell_value_q;
	logic                       in_range_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_valid) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid) begin
			glyph_index_q <= res_glyph_index;
			glyph_char_q  <= res_glyph_char;
			transparent_q <= res_transparent;
			cell_value_q  <= res_cell_value;
			in_range_q    <= res_in_range;
		end
	end

	assign out_valid   = out_valid_q;
	assign glyph_index = glyph_index_q;
	assign glyph_char  = glyph_char_q;
	assign transparent = transparent_q;
	assign cell_value  = cell_value_q;
	assign in_range    = in_range_q;

`ifndef SYNTHESIS
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		!(ctl_s1.valid && ctl_s2.valid))
		else $error("two items in the read-modify-write pipe");

	a_s1_from_accept: assert property (@(posedge clk) disable iff (!arst_n)
		ctl_s1.valid |-> $past(in_valid && !in_stall))
		else $error("stage 1 holds an item that was never accepted");

	a_wb_only_retire: assert property (@(posedge clk) disable iff (!arst_n)
		(wb_en && !clearing) |-> (ctl_s2.valid && ctl_s2.action != ACT_READ))
		else $error("cell write without a retiring write item");

	a_result_from_read: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(ctl_s2.valid && ctl_s2.action == ACT_READ))
		else $error("result beat not caused by a read");

	a_no_clobber: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> !$past(res_valid))
		else $error("waiting result overwritten");
`endif

endmodule

[design/blfb_cell_mem.sv]
// Cell store: single-port-write, single-port-read synchronous RAM with registered read data.
module blfb_cell_mem
	import blfb_pkg::*;
#(
	parameter int DEPTH      = MAX_WIDTH_DEF * MAX_HEIGHT_DEF,
	parameter int VALUE_BITS = VALUE_BITS_DEF,
	localparam int ADDR_W    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic                         clk,
	input  logic                         wr_en,
	input  logic [ADDR_W-1:0]            wr_addr,
	input  logic signed [VALUE_BITS-1:0] wr_data,
	input  logic                         rd_en,
	input  logic [ADDR_W-1:0]            rd_addr,
	output logic signed [VALUE_BITS-1:0] rd_data
);

	logic signed [VALUE_BITS-1:0] mem [DEPTH];
	logic signed [VALUE_BITS-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

[design/blfb_blend.sv]
// Blend datapath: clamp and multiply stage, then round, saturate, write-back and glyph quantise.
module blfb_blend
	import blfb_pkg::*;
#(
	parameter int VALUE_BITS = VALUE_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  item_ctl_t                    ctl_s1,
	input  logic signed [VAL_IN_W-1:0]   value_s1,
	input  logic signed [VALUE_BITS-1:0] old_s1,
	input  logic                         res_ready,
	output item_ctl_t                    ctl_s2,
	output logic                         wr_en,
	output logic signed [VALUE_BITS-1:0] wr_data,
	output logic                         res_valid,
	output logic [LEVEL_W-1:0]           res_glyph_index,
	output logic [CHAR_W-1:0]            res_glyph_char,
	output logic                         res_transparent,
	output logic signed [VAL_IN_W-1:0]   res_cell_value,
	output logic                         res_in_range
);

	localparam int A_W = VALUE_BITS + 2;
	localparam int B_W = N_W + 1;
	localparam int P_W = A_W + B_W;
	localparam logic signed [A_W-1:0]    ONE_A    = A_W'(FRAC_ONE);
	localparam logic signed [WIDE_W-1:0] ONE_W    = WIDE_W'(FRAC_ONE);
	localparam logic signed [WIDE_W-1:0] HALF_W   = WIDE_W'(FRAC_ONE / 2);
	localparam logic signed [WIDE_W-1:0] TOP_LVL  = WIDE_W'(LEVELS - 1);
	localparam logic signed [WIDE_W-1:0] CELL_MAX =
		WIDE_W'((64'sd1 <<< (VALUE_BITS - 1)) - 64'sd1);
	localparam logic signed [WIDE_W-1:0] CELL_MIN = -CELL_MAX - WIDE_W'(1);

	function automatic logic signed [VALUE_BITS-1:0] sat_cell(
		input logic signed [WIDE_W-1:0] v);
		logic signed [WIDE_W-1:0] r;
		r = v;
		if (r > CELL_MAX) r = CELL_MAX;
		if (r < CELL_MIN) r = CELL_MIN;
		return r[VALUE_BITS-1:0];
	endfunction

	// Stage 1: clamp and (1-old)(1-n)
	logic [N_W-1:0]          n_s1;
	logic signed [A_W-1:0]   a_s1;
	logic signed [B_W-1:0]   b_s1;
	logic signed [P_W-1:0]   prod_s1;

	always_comb begin
		if (value_s1[VAL_IN_W-1]) begin
			n_s1 = '0;
		end else if (value_s1 > VAL_IN_W'(FRAC_ONE)) begin
			n_s1 = N_W'(FRAC_ONE);
		end else begin
			n_s1 = value_s1[N_W-1:0];
		end
		a_s1    = ONE_A - A_W'(old_s1);
		b_s1    = $signed({1'b0, N_W'(N_W'(FRAC_ONE) - n_s1)});
		prod_s1 = a_s1 * b_s1;
	end

	// Stage 2 registers
	item_ctl_t                    ctl_s2_q;
	logic signed [P_W-1:0]        prod_s2;
	logic signed [VALUE_BITS-1:0] old_s2;
	logic [N_W-1:0]               n_s2;
	logic signed [VAL_IN_W-1:0]   val_s2;
	logic                         go_s2;

	assign go_s2 = ctl_s2_q.valid && (ctl_s2_q.action != ACT_READ || res_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s2_q <= '0;
		end else if (ctl_s1.valid) begin
			ctl_s2_q <= ctl_s1;
		end else if (go_s2) begin
			ctl_s2_q.valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl_s1.valid) begin
			prod_s2 <= prod_s1;
			old_s2  <= old_s1;
			n_s2    <= n_s1;
			val_s2  <= value_s1;
		end
	end

	// Stage 2: round, saturate, quantise
	logic signed [WIDE_W-1:0] old_w;
	logic signed [WIDE_W-1:0] n_w;
	logic signed [WIDE_W-1:0] q_w;
	logic signed [WIDE_W-1:0] lvl_w;
	logic [LEVEL_W-1:0]       lvl;

	always_comb begin
		old_w = WIDE_W'(old_s2);
		n_w   = WIDE_W'($signed({1'b0, n_s2}));
		// floor((p + 0.5) / 1.0): ties round up
		q_w   = (WIDE_W'(prod_s2) + HALF_W) >>> FRAC_BITS;
		case (ctl_s2_q.action)
			ACT_OVERWRITE: wr_data = sat_cell(n_w);
			ACT_ALPHA:     wr_data = sat_cell(ONE_W - q_w);
			ACT_ADD:       wr_data = sat_cell(old_w + n_w);
			ACT_FILL:      wr_data = sat_cell(WIDE_W'(val_s2));
			default:       wr_data = old_s2;
		endcase
		lvl_w = ((old_w <<< 3) - old_w + HALF_W) >>> FRAC_BITS;
		if (lvl_w > TOP_LVL) begin
			lvl = LEVEL_W'(LEVELS - 1);
		end else begin
			lvl = lvl_w[LEVEL_W-1:0];
		end
	end

	assign wr_en     = go_s2 && ctl_s2_q.action != ACT_READ;
	assign res_valid = go_s2 && ctl_s2_q.action == ACT_READ;
	assign ctl_s2    = ctl_s2_q;

	always_comb begin
		res_glyph_index = '0;
		res_glyph_char  = '0;
		res_transparent = 1'b0;
		res_cell_value  = '0;
		res_in_range    = ctl_s2_q.inr;
		if (ctl_s2_q.inr) begin
			res_cell_value  = old_w[VAL_IN_W-1:0];
			res_transparent = old_s2[VALUE_BITS-1];
			if (!old_s2[VALUE_BITS-1]) begin
				res_glyph_index = lvl;
				res_glyph_char  = shade_char(lvl);
			end
		end
	end

endmodule

[tb/sv/blend_framebuffer_glyph_readout_tb.sv]
// Self-checking testbench for the glyph readout framebuffer: directed table, random beats, predictor.
module blend_framebuffer_glyph_readout_tb;
	import blfb_pkg::*;

	// Actions the block must drop without a result
	localparam logic [2:0] ACT_SPARE_5 = 3'd5;
	localparam logic [2:0] ACT_SPARE_7 = 3'd7;

	// Shade characters, level 0 in the top byte
	localparam logic [63:0] SHADE_SET = " -~+=o&@";

	localparam longint Q_MAX = (longint'(1) <<< (VALUE_BITS_DEF - 1)) - 1;
	localparam longint Q_MIN = -Q_MAX - 1;

	// Cycles with no beat on either channel before the run is abandoned. The clearing
	// sweep after reset and the long receiver hold-off both leave the channels quiet,
	// so this sits well above either.
	localparam int QUIET_LIMIT = 100000;
	localparam int HOLD_SPAN   = 400;
	// Pipeline is three deep; let the last write drain before touching the grid size
	localparam int DRAIN_CYCLES = 8;
	localparam int N_PHASES     = 5;

	typedef struct packed {
		logic [LEVEL_W-1:0]         glyph;
		logic [CHAR_W-1:0]          chr;
		logic                       transp;
		logic signed [VAL_IN_W-1:0] raw;
		logic                       inr;
	} glyph_res_t;

	typedef struct packed {
		logic [2:0]                 act;
		logic signed [COORD_W-1:0]  xc;
		logic signed [COORD_W-1:0]  yc;
		logic signed [VAL_IN_W-1:0] vv;
		logic                       pin;
		glyph_res_t                 res;
	} warm_row_t;

	localparam glyph_res_t NO_CELL    = '{3'd0, 8'h00, 1'b0, 16'sd0, 1'b0};
	localparam glyph_res_t CELL_BLANK = '{3'd0, 8'h20, 1'b0, 16'sd0, 1'b1};
	localparam glyph_res_t NO_CHECK   = '0;

	// Directed table: read-back values typed in only where they are obvious
	// (cleared grid, out-of-grid reads, full scale, transparent cells).
	warm_row_t warm_rows [25] = '{
		'{ACT_READ,      0,     0,      0,      1'b1, CELL_BLANK},
		'{ACT_READ,      255,   127,    0,      1'b1, CELL_BLANK},
		'{ACT_READ,      256,   0,      0,      1'b1, NO_CELL},
		'{ACT_READ,      -1,    -32768, 0,      1'b1, NO_CELL},
		'{ACT_READ,      32767, 32767,  -1,     1'b1, NO_CELL},
		'{ACT_OVERWRITE, 0,     0,      32767,  1'b0, NO_CHECK},
		'{ACT_READ,      0,     0,      0,      1'b1, '{3'd7, 8'h40, 1'b0, 16'sd4096, 1'b1}},
		'{ACT_ALPHA,     0,     0,      2048,   1'b0, NO_CHECK},
		'{ACT_SPARE_7,   0,     0,      -32768, 1'b0, NO_CHECK},
		'{ACT_READ,      0,     0,      0,      1'b0, NO_CHECK},
		'{ACT_FILL,      1,     0,      -32768, 1'b0, NO_CHECK},
		'{ACT_READ,      1,     0,      0,      1'b1, '{3'd0, 8'h00, 1'b1, -16'sd32768, 1'b1}},
		'{ACT_FILL,      2,     0,      32767,  1'b0, NO_CHECK},
		'{ACT_ADD,       2,     0,      4096,   1'b0, NO_CHECK},
		'{ACT_READ,      2,     0,      0,      1'b1, '{3'd7, 8'h40, 1'b0, 16'sd32767, 1'b1}},
		'{ACT_ALPHA,     2,     0,      1,      1'b0, NO_CHECK},
		'{ACT_READ,      2,     0,      0,      1'b0, NO_CHECK},
		'{ACT_ALPHA,     1,     0,      0,      1'b0, NO_CHECK},
		'{ACT_READ,      1,     0,      0,      1'b0, NO_CHECK},
		'{ACT_OVERWRITE, 3,     0,      -5,     1'b0, NO_CHECK},
		'{ACT_ADD,       3,     0,      293,    1'b0, NO_CHECK},
		'{ACT_READ,      3,     0,      0,      1'b0, NO_CHECK},
		'{ACT_OVERWRITE, 256,   0,      4096,   1'b0, NO_CHECK},
		'{ACT_FILL,      255,   127,    -1,     1'b0, NO_CHECK},
		'{ACT_READ,      255,   127,    0,      1'b1, '{3'd0, 8'h00, 1'b1, -16'sd1, 1'b1}}
	};

	// Grid settings per random phase: extremes, a zero-width grid and oversize values
	// that the block must cut down to its maximum.
	int ph_w     [N_PHASES] = '{256, 1,   173, 0,   511};
	int ph_h     [N_PHASES] = '{128, 1,   90,  255, 7};
	int ph_beats [N_PHASES] = '{200, 150, 200, 60,  200};
	int ph_idle  [N_PHASES] = '{0,   83,  0,   23,  23};
	int ph_stall [N_PHASES] = '{0,   0,   83,  23,  83};

	logic                       clk = 1'b0;
	logic                       arst_n = 1'b0;
	logic                       cfg_we = 1'b0;
	logic                       cfg_index = 1'b0;
	logic [CFG_W-1:0]           cfg_data = '0;
	logic                       in_valid = 1'b0;
	logic                       in_stall;
	logic [2:0]                 action = '0;
	logic signed [COORD_W-1:0]  x_coord = '0;
	logic signed [COORD_W-1:0]  y_coord = '0;
	logic signed [VAL_IN_W-1:0] value = '0;
	logic                       out_valid;
	logic                       out_stall = 1'b0;
	logic [LEVEL_W-1:0]         glyph_index;
	logic [CHAR_W-1:0]          glyph_char;
	logic                       transparent;
	logic signed [VAL_IN_W-1:0] cell_value;
	logic                       in_range;

	// Predictor state: its own copy of the grid and of the two size registers
	logic signed [VALUE_BITS_DEF-1:0] cells [MAX_WIDTH_DEF*MAX_HEIGHT_DEF];
	logic [WIDTH_W-1:0]               grid_w = ACTIVE_WIDTH_RST;
	logic [HEIGHT_W-1:0]              grid_h = ACTIVE_HEIGHT_RST;

	glyph_res_t due_glyphs [$];
	glyph_res_t pin_res = '0;
	bit         pin_now = 1'b0;

	int glyph_mismatches = 0;
	int beats_sent = 0;
	int reads_checked = 0;
	int src_idle_pct = 0;
	int sink_stall_pct = 0;
	int hold_req = 0;
	int hold_seen = 0;
	int hold_left = 0;
	int quiet = 0;

	blend_framebuffer_glyph_readout i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.action      (action),
		.x_coord     (x_coord),
		.y_coord     (y_coord),
		.value       (value),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.glyph_index (glyph_index),
		.glyph_char  (glyph_char),
		.transparent (transparent),
		.cell_value  (cell_value),
		.in_range    (in_range)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic logic signed [VALUE_BITS_DEF-1:0] clip_q(input longint v);
		if (v > Q_MAX)
			return Q_MAX[VALUE_BITS_DEF-1:0];
		if (v < Q_MIN)
			return Q_MIN[VALUE_BITS_DEF-1:0];
		return v[VALUE_BITS_DEF-1:0];
	endfunction

	// Applies one beat to the predicted grid; returns 1 with the glyph for a read
	function automatic bit plot_cell(input logic [2:0] act, input logic signed [15:0] xc,
			input logic signed [15:0] yc, input logic signed [15:0] vv, output glyph_res_t res);
		longint xi, yi, vi, ew, eh, old, n, p, nv, lvl;
		bit     inr;
		int     idx;
		xi = xc;
		yi = yc;
		vi = vv;
		ew = (grid_w < MAX_WIDTH_DEF) ? grid_w : MAX_WIDTH_DEF;
		eh = (grid_h < MAX_HEIGHT_DEF) ? grid_h : MAX_HEIGHT_DEF;
		inr = xi >= 0 && xi < ew && yi >= 0 && yi < eh;
		idx = inr ? int'(xi * MAX_HEIGHT_DEF + yi) : 0;
		res = '0;
		if (act == ACT_READ) begin
			if (inr) begin
				old = cells[idx];
				res.raw = cells[idx];
				res.inr = 1'b1;
				if (old < 0) begin
					res.transp = 1'b1;
				end else begin
					lvl = (old * (LEVELS - 1) + FRAC_ONE / 2) / FRAC_ONE;
					if (lvl > LEVELS - 1)
						lvl = LEVELS - 1;
					res.glyph = lvl[LEVEL_W-1:0];
					res.chr = SHADE_SET[63 - 8 * lvl -: 8];
				end
			end
			return 1'b1;
		end
		if (act > ACT_FILL || !inr)
			return 1'b0;
		old = cells[idx];
		n = (vi < 0) ? 0 : ((vi > FRAC_ONE) ? FRAC_ONE : vi);
		case (act)
			ACT_FILL:      nv = vi;
			ACT_OVERWRITE: nv = n;
			ACT_ALPHA: begin
				// 1-(1-old)(1-new), product rounded to nearest with ties upward
				p = (FRAC_ONE - old) * (FRAC_ONE - n);
				nv = FRAC_ONE - ((p + FRAC_ONE / 2) >>> FRAC_BITS);
			end
			default:       nv = old + n;
		endcase
		cells[idx] = clip_q(nv);
		return 1'b0;
	endfunction

	// Scoreboard: result beats first, then register writes, then the item beat, so a
	// result never meets the expectation of the beat taken at the same edge.
	always @(posedge clk) begin
		glyph_res_t got, want;
		bit         is_read;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				got = {glyph_index, glyph_char, transparent, cell_value, in_range};
				if (due_glyphs.size() == 0) begin
					if (glyph_mismatches < 10)
						$display({"%0t: result beat with no read waiting ",
							"(idx %0d char %h tr %b val %0d inr %b)"},
							$realtime, got.glyph, got.chr, got.transp, got.raw, got.inr);
					glyph_mismatches++;
				end else begin
					want = due_glyphs.pop_front();
					reads_checked++;
					if (got.glyph !== want.glyph || got.chr !== want.chr ||
							got.transp !== want.transp || got.raw !== want.raw ||
							got.inr !== want.inr) begin
						if (glyph_mismatches < 10)
							$display({"%0t: glyph mismatch, ",
								"exp idx %0d char %h tr %b val %0d inr %b, ",
								"got idx %0d char %h tr %b val %0d inr %b"},
								$realtime, want.glyph, want.chr, want.transp, want.raw,
								want.inr, got.glyph, got.chr, got.transp, got.raw, got.inr);
						glyph_mismatches++;
					end
				end
			end
			if (cfg_we) begin
				if (cfg_index == CFG_ACTIVE_WIDTH)
					grid_w = cfg_data[WIDTH_W-1:0];
				else
					grid_h = cfg_data[HEIGHT_W-1:0];
			end
			if (in_valid && !in_stall) begin
				beats_sent++;
				is_read = plot_cell(action, x_coord, y_coord, value, want);
				if (is_read)
					due_glyphs.push_back(pin_now ? pin_res : want);
			end
		end
	end

	// Receiver: random stalls, plus one long hold-off on request so the pipe backs up
	always @(negedge clk) begin
		if (hold_seen != hold_req) begin
			hold_seen = hold_req;
			hold_left = HOLD_SPAN;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < sink_stall_pct);
		end
	end

	// Watchdog on beats, not on total run time
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
			quiet = 0;
		end else begin
			quiet++;
			if (quiet >= QUIET_LIMIT) begin
				$display("watchdog: no beat for %0d cycles, %0d reads outstanding",
					quiet, due_glyphs.size());
				$display("CHECKS FAILED");
				$finish;
			end
		end
	end

	// Called at a falling edge; returns at the falling edge after the beat is taken
	task automatic offer_beat(input logic [2:0] act, input logic [15:0] xc,
			input logic [15:0] yc, input logic [15:0] vv, input bit pin,
			input glyph_res_t res);
		while ($urandom_range(99) < src_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		pin_now = pin;
		pin_res = res;
		in_valid <= 1'b1;
		action <= act;
		x_coord <= xc;
		y_coord <= yc;
		value <= vv;
		do
			@(posedge clk);
		while (in_stall);
		@(negedge clk);
	endtask

	task automatic set_grid(input int w, input int h);
		cfg_we <= 1'b1;
		cfg_index <= CFG_ACTIVE_WIDTH;
		cfg_data <= w[CFG_W-1:0];
		@(negedge clk);
		cfg_index <= CFG_ACTIVE_HEIGHT;
		cfg_data <= h[CFG_W-1:0];
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// Stop sending, let every read come back and the last writes drain
	task automatic settle();
		in_valid <= 1'b0;
		while (due_glyphs.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	// Mostly a few cells near either corner so beats pile onto the same cells;
	// some at the grid edges and some anywhere in the 16-bit range.
	function automatic logic [15:0] pick_coord(input int lim);
		int r, span;
		r = $urandom_range(99);
		span = (lim < 6) ? lim : 6;
		if (r < 10 || lim <= 0)
			return (r < 50) ? 16'($urandom()) : 16'($urandom_range(3));
		if (r < 25) begin
			case ($urandom_range(3))
				0:       return 16'(lim - 1);
				1:       return 16'(lim);
				2:       return 16'(-1);
				default: return 16'(0);
			endcase
		end
		if (r < 60)
			return 16'($urandom_range(span - 1));
		return 16'(lim - 1 - int'($urandom_range(span - 1)));
	endfunction

	function automatic logic [15:0] pick_level();
		int r;
		r = $urandom_range(99);
		if (r < 50)
			return 16'($urandom_range(FRAC_ONE));
		if (r < 65)
			return 16'(FRAC_ONE - 4 + int'($urandom_range(8)));
		// around the rounding step between two shade levels
		if (r < 75)
			return 16'(int'($urandom_range(LEVELS - 1)) * 585 + 291 +
				int'($urandom_range(3)));
		return 16'($urandom());
	endfunction

	function automatic logic [2:0] pick_action();
		int r;
		r = $urandom_range(99);
		if (r < 35) return ACT_READ;
		if (r < 50) return ACT_OVERWRITE;
		if (r < 65) return ACT_ALPHA;
		if (r < 80) return ACT_ADD;
		if (r < 95) return ACT_FILL;
		return 3'(ACT_SPARE_5 + $urandom_range(2));
	endfunction

	initial begin
		int ew, eh;
		foreach (cells[i])
			cells[i] = '0;
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;

		// Block is sweeping its RAM now; size writes are taken during the sweep
		set_grid(ACTIVE_WIDTH_RST, ACTIVE_HEIGHT_RST);
		foreach (warm_rows[i])
			offer_beat(warm_rows[i].act, warm_rows[i].xc, warm_rows[i].yc,
				warm_rows[i].vv, warm_rows[i].pin, warm_rows[i].res);

		for (int ph = 0; ph < N_PHASES; ph++) begin
			settle();
			set_grid(ph_w[ph], ph_h[ph]);
			ew = (ph_w[ph] < MAX_WIDTH_DEF) ? ph_w[ph] : MAX_WIDTH_DEF;
			eh = (ph_h[ph] % 256 < MAX_HEIGHT_DEF) ? ph_h[ph] % 256 : MAX_HEIGHT_DEF;
			src_idle_pct = ph_idle[ph];
			sink_stall_pct = ph_stall[ph];
			// Back-pressure: receiver holds off while beats keep coming at full rate
			if (ph == 0)
				hold_req++;
			repeat (ph_beats[ph])
				offer_beat(pick_action(), pick_coord(ew), pick_coord(eh), pick_level(),
					1'b0, NO_CHECK);
		end

		settle();
		repeat (16) @(posedge clk);
		$display("framebuffer run: %0d item beats, %0d read results checked, %0d mismatches",
			beats_sent, reads_checked, glyph_mismatches);
		$display({"covered %0d grid sizes incl. zero and oversize, ",
			"idle/stall mixes and a long hold-off"}, N_PHASES);
		if (glyph_mismatches == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
